/* design/timed_dismissal_table_unit_assert.svh */
// Assertion macros shared by the checker of the dismissal table unit.
// Each macro uses the clk and rst signals of the scope it is expanded in.
`ifndef TIMED_DISMISSAL_TABLE_UNIT_ASSERT_SVH
`define TIMED_DISMISSAL_TABLE_UNIT_ASSERT_SVH

// The consequent must follow whenever the antecedent holds outside reset.
`define TDT_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tdt implication violated");

// The condition must never hold outside reset.
`define TDT_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("tdt forbidden condition seen");

`endif

/* design/tdt_pkg.sv */
package tdt_pkg;

  // Fixed field widths.
  localparam int KEY_W  = 64;
  localparam int TIME_W = 32;
  localparam int GRACE_W = 16;
  localparam int MODE_W = 2;

  // Defaults for the top-level parameters.
  localparam int ENTRIES_DEFAULT   = 4;
  localparam int KEY_BYTES_DEFAULT = 8;

  // Depth of the request queue between front and back; a power of two.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam logic [GRACE_W-1:0] GRACE_RESET = 16'd120;

  // Operation codes carried on the mode field.
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RECORD = 2'd1;
  localparam logic [MODE_W-1:0] MODE_EXPIRE = 2'd2;

  // A classified request as it waits in the queue.
  typedef struct packed {
    logic [MODE_W-1:0] op;
    logic              key_empty;
    logic [KEY_W-1:0]  key_val;
    logic [TIME_W-1:0] now_val;
    logic [TIME_W-1:0] stop_val;
  } req_t;

  // Queue occupancy as seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* design/tdt_front.sv */
module tdt_front import tdt_pkg::*; #(
  parameter int KEY_BYTES = KEY_BYTES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [MODE_W-1:0]  mode,
  input  logic [KEY_W-1:0]   key,
  input  logic [TIME_W-1:0]  now_time,
  input  logic [TIME_W-1:0]  start_time,
  input  logic [TIME_W-1:0]  end_time,
  input  logic               has_end,
  input  logic               grace_we,
  input  logic [GRACE_W-1:0] grace_wdata,
  input  q_stat_t            q_stat,
  output logic               busy,
  output logic               push,
  output req_t               push_req
);

  localparam int KeyW = 8 * KEY_BYTES;

  logic [GRACE_W-1:0] grace;
  logic [TIME_W:0]    grace_sum;
  logic [TIME_W-1:0]  grace_stop;

  // Grace period register.
  always_ff @(posedge clk) begin
    if (rst) begin
      grace <= GRACE_RESET;
    end else if (grace_we) begin
      grace <= grace_wdata;
    end
  end

  // Start time plus grace, saturating at the top of the time range.
  assign grace_sum  = {1'b0, start_time} + {{(TIME_W + 1 - GRACE_W){1'b0}}, grace};
  assign grace_stop = grace_sum[TIME_W] ? {TIME_W{1'b1}} : grace_sum[TIME_W-1:0];

  // A request is taken whenever the queue has room.
  assign busy = q_stat.full;
  assign push = start && !busy;

  // Classify the request: empty-key detection and end time selection.
  always_comb begin
    push_req.op        = mode;
    push_req.key_empty = (key[KeyW-1:0] == '0);
    push_req.key_val   = key;
    push_req.now_val   = now_time;
    push_req.stop_val  = (has_end && (end_time > start_time)) ? end_time : grace_stop;
  end

endmodule

/* design/tdt_queue.sv */
module tdt_queue import tdt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  req_t    push_req,
  input  logic    pop,
  output req_t    pop_req,
  output q_stat_t q_stat
);

  req_t                 slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0]   count;
  logic                   do_push;
  logic                   do_pop;

  assign q_stat.full  = (count == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);
  assign do_push = push && !q_stat.full;
  assign do_pop  = pop && !q_stat.empty;
  assign pop_req = slots[rd_ptr];

  // Pointers and fill count; the depth is a power of two so pointers wrap.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Request storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_req;
    end
  end

endmodule

/* design/tdt_back.sv */
module tdt_back import tdt_pkg::*; #(
  parameter int ENTRIES   = ENTRIES_DEFAULT,
  parameter int KEY_BYTES = KEY_BYTES_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  req_t req,
  output logic done,
  output logic status,
  output logic blocked
);

  localparam int KeyW = 8 * KEY_BYTES;
  localparam int IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [KeyW-1:0]   key_q  [ENTRIES];
  logic [TIME_W-1:0] dis_q  [ENTRIES];
  logic [TIME_W-1:0] stop_q [ENTRIES];

  logic [KeyW-1:0]   rkey;
  logic              hit_found;
  logic [IdxW-1:0]   hit_idx;
  logic              slot_found;
  logic [IdxW-1:0]   slot_idx;
  logic [ENTRIES-1:0] expire_mask;
  logic              do_record;
  logic              do_expire;
  logic              blocked_next;
  logic              status_next;

  assign rkey = req.key_val[KeyW-1:0];

  // Parallel compare of all slots with a priority pick of the lowest index.
  always_comb begin
    hit_found   = 1'b0;
    hit_idx     = '0;
    slot_found  = 1'b0;
    slot_idx    = '0;
    expire_mask = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!hit_found && (key_q[i] == rkey)) begin
        hit_found = 1'b1;
        hit_idx   = IdxW'(i);
      end
      if (!slot_found && ((key_q[i] == '0) || (key_q[i] == rkey))) begin
        slot_found = 1'b1;
        slot_idx   = IdxW'(i);
      end
      expire_mask[i] = (key_q[i] != '0) && (req.now_val >= stop_q[i]);
    end
  end

  // Decide the outcome of the request at the head of the queue.
  always_comb begin
    do_record    = 1'b0;
    do_expire    = 1'b0;
    blocked_next = 1'b0;
    status_next  = 1'b0;
    case (req.op)
      MODE_QUERY: begin
        blocked_next = !req.key_empty && hit_found &&
                       (req.now_val < stop_q[hit_idx]) &&
                       (req.now_val >= dis_q[hit_idx]);
      end
      MODE_RECORD: begin
        status_next = req.key_empty;
        do_record   = req_valid && !req.key_empty;
      end
      MODE_EXPIRE: begin
        do_expire = req_valid;
      end
      default: begin
        blocked_next = 1'b0;
      end
    endcase
  end

  // Key store: cleared at reset, emptied by expiry, filled by record.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        key_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (do_record && (slot_idx == IdxW'(i))) begin
          key_q[i] <= rkey;
        end else if (do_expire && expire_mask[i]) begin
          key_q[i] <= '0;
        end
      end
    end
  end

  // Times only matter while the key of their slot is non-empty.
  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (do_record && (slot_idx == IdxW'(i))) begin
        dis_q[i]  <= req.now_val;
        stop_q[i] <= req.stop_val;
      end
    end
  end

  // Registered result, shown for one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      done    <= 1'b0;
      status  <= 1'b0;
      blocked <= 1'b0;
    end else begin
      done    <= req_valid;
      status  <= req_valid && status_next;
      blocked <= req_valid && blocked_next;
    end
  end

endmodule

/* design/timed_dismissal_table_unit.sv */
// Table of dismissed alert keys with dismissal and end times.
// Requests: pulse start with mode, key, now_time, start_time, end_time and
// has_end; a request is taken at a clock edge where start is high and busy
// is low. Mode 0 queries a key, mode 1 records a dismissal, mode 2 expires
// every entry whose end time has been reached.
// Results: every request gives one result, marked by done for exactly one
// cycle with status (1 for a record with an empty key) and blocked (the
// query answer). The receiver cannot stall; results are never held back.
// Each accepted request passes through a queue slot and then the result
// register before done rises.
// One request per cycle is sustained: the back end settles each request
// through a parallel compare of all table slots, so the
// queue between front and back never fills and busy never rises.
// The grace period register is written through grace_we and grace_wdata.
// Reset (rst, synchronous) empties the table, the queue and the result
// register, and sets the grace period to 120.
module timed_dismissal_table_unit import tdt_pkg::*; #(
  parameter int ENTRIES   = ENTRIES_DEFAULT,
  parameter int KEY_BYTES = KEY_BYTES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [MODE_W-1:0]  mode,
  input  logic [KEY_W-1:0]   key,
  input  logic [TIME_W-1:0]  now_time,
  input  logic [TIME_W-1:0]  start_time,
  input  logic [TIME_W-1:0]  end_time,
  input  logic               has_end,
  input  logic               grace_we,
  input  logic [GRACE_W-1:0] grace_wdata,
  output logic               done,
  output logic               status,
  output logic               blocked
);

  logic    push;
  req_t    push_req;
  req_t    pop_req;
  q_stat_t q_stat;

  // Front end: takes and classifies requests.
  tdt_front #(
    .KEY_BYTES (KEY_BYTES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .mode        (mode),
    .key         (key),
    .now_time    (now_time),
    .start_time  (start_time),
    .end_time    (end_time),
    .has_end     (has_end),
    .grace_we    (grace_we),
    .grace_wdata (grace_wdata),
    .q_stat      (q_stat),
    .busy        (busy),
    .push        (push),
    .push_req    (push_req)
  );

  // Request queue between the two halves.
  tdt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_req (push_req),
    .pop      (!q_stat.empty),
    .pop_req  (pop_req),
    .q_stat   (q_stat)
  );

  // Back end: operates on the table and produces the result.
  tdt_back #(
    .ENTRIES   (ENTRIES),
    .KEY_BYTES (KEY_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .req_valid (!q_stat.empty),
    .req       (pop_req),
    .done      (done),
    .status    (status),
    .blocked   (blocked)
  );

endmodule

/* design/tdt_checker.sv */
`include "timed_dismissal_table_unit_assert.svh"

module tdt_checker import tdt_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic [MODE_W-1:0] mode,
  input logic              done,
  input logic              status,
  input logic              blocked
);

  // Every accepted request is followed by its result, after the queue slot and the result register.
  `TDT_ASSERT_IMPLIES(a_result_follows, start && !busy, ##2 done)

  // No result appears without an accepted request before it.
  `TDT_ASSERT_IMPLIES(a_no_spurious, done, $past(start && !busy && !rst, 2))

  // An invalid status only answers a record request.
  `TDT_ASSERT_IMPLIES(a_status_record, done && status, $past(mode, 2) == MODE_RECORD)

  // A blocked answer only comes from a query.
  `TDT_ASSERT_IMPLIES(a_blocked_query, done && blocked, $past(mode, 2) == MODE_QUERY)

  // Status and blocked never both set.
  `TDT_ASSERT_NEVER(a_exclusive, status && blocked)

endmodule

bind timed_dismissal_table_unit tdt_checker u_tdt_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .mode    (mode),
  .done    (done),
  .status  (status),
  .blocked (blocked)
);
